// File: rtl/core/sorted_key_run_group_counter_top_assert.svh
// assertion macros used by the emitter in the core
// every macro expects clk and arst_n in scope
`ifndef SORTED_KEY_RUN_GROUP_COUNTER_TOP_ASSERT_SVH
`define SORTED_KEY_RUN_GROUP_COUNTER_TOP_ASSERT_SVH

// condition must never hold
`define SKRGC_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// consequent holds in the same cycle
`define SKRGC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the next cycle
`define SKRGC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/skrgc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package skrgc_pkg;

	localparam int KEY_FIELDS = 4;
	localparam int GROUP_SLOTS = 8;
	localparam int KEY_W = 32;
	localparam int GROUP_W = 3;
	localparam int CNT_W = 20;
	localparam int NUM_W = 20;
	localparam int COV_W = 3;
	localparam int GCNT_W = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 4;

	localparam int DEF_MAX_KEYS = 4;
	localparam int DEF_MAX_GROUPS = 8;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [COV_W-1:0] COV_RESET = 3'd4;
	localparam logic [GCNT_W-1:0] GCNT_RESET = 4'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_COV = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_GRP = 1'd1;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// input request: keys, group, padding
	localparam int S_DATA_W = ((KEY_FIELDS * KEY_W + GROUP_W + 7) / 8) * 8;
	// result: number, keys, group, count, padding
	localparam int M_PAYLOAD_W = NUM_W + KEY_FIELDS * KEY_W + GROUP_W + CNT_W;
	localparam int M_DATA_W = ((M_PAYLOAD_W + 7) / 8) * 8;

	// control broadcast to the group count lanes
	typedef struct packed {
		logic record;
		logic close;
		logic [GROUP_W-1:0] grp;
		logic [GCNT_W-1:0] ng;
	} cnt_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/skrgc_key_lane.sv
`timescale 1ns / 1ps
`default_nettype none

// one word of the stored key and its comparator
module skrgc_key_lane #(
	parameter int LANE = 0
) (
	input  wire logic clk,
	input  wire logic load,
	input  wire logic [skrgc_pkg::KEY_W-1:0] key,
	input  wire logic [skrgc_pkg::COV_W-1:0] nk,
	output logic [skrgc_pkg::KEY_W-1:0] prev,
	output logic differs
);

	logic [skrgc_pkg::KEY_W-1:0] prev_q;

	always_ff @(posedge clk) begin
		if (load) begin
			prev_q <= key;
		end
	end

	assign prev = prev_q;
	assign differs = (skrgc_pkg::COV_W'(LANE) < nk) && (key != prev_q);

endmodule

`default_nettype wire

// File: rtl/core/skrgc_count_lane.sv
`timescale 1ns / 1ps
`default_nettype none

// member counter of one group, with a snapshot for the emitter
module skrgc_count_lane #(
	parameter int LANE = 0
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire skrgc_pkg::cnt_ctl_t ctl,
	output logic [skrgc_pkg::CNT_W-1:0] snap
);

	logic [skrgc_pkg::CNT_W-1:0] count_q;
	logic [skrgc_pkg::CNT_W-1:0] snap_q;
	logic hit;

	assign hit = ctl.record && (ctl.grp == skrgc_pkg::GROUP_W'(LANE))
		&& (skrgc_pkg::GCNT_W'(LANE) < ctl.ng);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.close) begin
			count_q <= hit ? skrgc_pkg::CNT_W'(1) : '0;
		end else if (hit && (count_q != skrgc_pkg::CNT_MAX)) begin
			count_q <= count_q + skrgc_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.close) begin
			snap_q <= count_q;
		end
	end

	assign snap = snap_q;

endmodule

`default_nettype wire

// File: rtl/core/skrgc_emit.sv
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_key_run_group_counter_top_assert.svh"

// walks the closed stratum, one group result per cycle while m_tready stays high
module skrgc_emit #(
	parameter int KEY_LANES = skrgc_pkg::DEF_MAX_KEYS,
	parameter int GROUP_LANES = skrgc_pkg::DEF_MAX_GROUPS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [skrgc_pkg::KEY_W-1:0] start_keys [KEY_LANES],
	input  wire logic [skrgc_pkg::NUM_W-1:0] start_num,
	input  wire logic [skrgc_pkg::GCNT_W-1:0] start_ng,
	input  wire logic [skrgc_pkg::CNT_W-1:0] counts [GROUP_LANES],
	output logic busy,
	output logic m_tvalid,
	input  wire logic m_tready,
	// number, key 0..3, group, count, zero pad
	output logic [skrgc_pkg::M_DATA_W-1:0] m_tdata,
	output logic m_tlast
);

	localparam int IDX_W = $clog2(GROUP_LANES);

	logic active_q;
	logic [IDX_W-1:0] idx_q;
	logic [skrgc_pkg::GCNT_W-1:0] ng_q;
	logic [skrgc_pkg::NUM_W-1:0] num_q;
	logic [skrgc_pkg::KEY_W-1:0] key_q [KEY_LANES];

	logic out_valid_q;
	logic out_last_q;
	logic [skrgc_pkg::GROUP_W-1:0] out_grp_q;
	logic [skrgc_pkg::CNT_W-1:0] out_cnt_q;
	logic [skrgc_pkg::NUM_W-1:0] out_num_q;
	logic [skrgc_pkg::KEY_W-1:0] out_key_q [skrgc_pkg::KEY_FIELDS];

	logic advance;
	logic is_last;
	logic [skrgc_pkg::KEY_W-1:0] key_word [skrgc_pkg::KEY_FIELDS];

	assign advance = active_q && (!out_valid_q || m_tready);
	assign is_last = (skrgc_pkg::GCNT_W'(idx_q) + skrgc_pkg::GCNT_W'(1)) == ng_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			if (start) begin
				active_q <= 1'b1;
				idx_q <= '0;
			end else if (advance) begin
				if (is_last) begin
					active_q <= 1'b0;
				end
				idx_q <= idx_q + IDX_W'(1);
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				out_last_q <= is_last;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ng_q <= start_ng;
			num_q <= start_num;
			key_q <= start_keys;
		end
		if (advance) begin
			out_grp_q <= skrgc_pkg::GROUP_W'(idx_q);
			out_cnt_q <= counts[idx_q];
			out_num_q <= num_q;
			out_key_q <= key_word;
		end
	end

	// key of the stratum is fixed while it is walked; words with no lane read zero
	for (genvar k = 0; k < skrgc_pkg::KEY_FIELDS; k++) begin : g_key
		if (k < KEY_LANES) begin : g_lane
			assign key_word[k] = key_q[k];
		end else begin : g_zero
			assign key_word[k] = '0;
		end
	end

	assign busy = active_q;
	assign m_tvalid = out_valid_q;
	assign m_tlast = out_last_q;
	assign m_tdata = skrgc_pkg::M_DATA_W'({out_cnt_q, out_grp_q, out_key_q[3], out_key_q[2],
		out_key_q[1], out_key_q[0], out_num_q});

	`SKRGC_ASSERT_NEVER(a_no_restart, start && active_q, "stratum closed while emitting")
	`SKRGC_ASSERT_IMPL(a_idx_range, active_q, skrgc_pkg::GCNT_W'(idx_q) < ng_q, "index past end")
	`SKRGC_ASSERT_NEXT(a_progress, active_q && !out_valid_q, out_valid_q, "emitter stalled")
	`SKRGC_ASSERT_NEXT(a_last_done, advance && is_last, !active_q, "walk went on after last")

endmodule

`default_nettype wire

// File: rtl/core/sorted_key_run_group_counter_top.sv
// a record closing a stratum, or a flush of an open one, sets emitter active_q, then out_valid_q
// throughput: one request per cycle while the key repeats
// a closed stratum holds s_tready low while the emitter walks
// the group counts, one result per cycle when m_tready stays high
// reset: arst_n clears stratum state, counts and the stratum number; config goes to 4 keys, 2 groups
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_run_group_counter_top #(
	parameter int MAX_KEYS = skrgc_pkg::DEF_MAX_KEYS,
	parameter int MAX_GROUPS = skrgc_pkg::DEF_MAX_GROUPS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [skrgc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [skrgc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic s_tvalid,
	output logic s_tready,
	// key_0, key_1, key_2, key_3, group, zero pad
	input  wire logic [skrgc_pkg::S_DATA_W-1:0] s_tdata,
	// op
	input  wire logic s_tuser,
	output logic m_tvalid,
	input  wire logic m_tready,
	// stratum_number, out_key_0..out_key_3, group_out, member_count, zero pad
	output logic [skrgc_pkg::M_DATA_W-1:0] m_tdata,
	output logic m_tlast
);

	// only as many key words and groups as can ever be in effect get a lane
	localparam int KEY_LANES = (MAX_KEYS < skrgc_pkg::KEY_FIELDS) ? MAX_KEYS
		: skrgc_pkg::KEY_FIELDS;
	localparam int GROUP_LANES = (MAX_GROUPS < skrgc_pkg::GROUP_SLOTS) ? MAX_GROUPS
		: skrgc_pkg::GROUP_SLOTS;

	// config registers
	logic [skrgc_pkg::COV_W-1:0] cov_q;
	logic [skrgc_pkg::GCNT_W-1:0] gcnt_q;

	// stratum state
	logic open_q;
	logic [skrgc_pkg::NUM_W-1:0] stratum_q;

	logic [skrgc_pkg::COV_W-1:0] nk;
	logic [skrgc_pkg::GCNT_W-1:0] ng;
	logic accept;
	logic record;
	logic flush;
	logic differs;
	logic close;
	logic load_key;
	logic busy;
	logic [skrgc_pkg::GROUP_W-1:0] grp;
	logic [KEY_LANES-1:0] lane_differs;
	logic [skrgc_pkg::KEY_W-1:0] lane_prev [KEY_LANES];
	logic [skrgc_pkg::KEY_W-1:0] masked_key [KEY_LANES];
	logic [skrgc_pkg::CNT_W-1:0] snap_counts [GROUP_LANES];
	skrgc_pkg::cnt_ctl_t cnt_ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cov_q <= skrgc_pkg::COV_RESET;
			gcnt_q <= skrgc_pkg::GCNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				skrgc_pkg::CFG_IDX_COV: cov_q <= cfg_wdata[skrgc_pkg::COV_W-1:0];
				skrgc_pkg::CFG_IDX_GRP: gcnt_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// effective key words and groups: zero acts as one, clamp to the lanes built
	always_comb begin
		priority if (cov_q == '0) begin
			nk = skrgc_pkg::COV_W'(1);
		end else if (cov_q > skrgc_pkg::COV_W'(KEY_LANES)) begin
			nk = skrgc_pkg::COV_W'(KEY_LANES);
		end else begin
			nk = cov_q;
		end
		priority if (gcnt_q == '0) begin
			ng = skrgc_pkg::GCNT_W'(1);
		end else if (gcnt_q > skrgc_pkg::GCNT_W'(GROUP_LANES)) begin
			ng = skrgc_pkg::GCNT_W'(GROUP_LANES);
		end else begin
			ng = gcnt_q;
		end
	end

	// one request at a time is held off only while a closed stratum is emitted
	assign s_tready = !busy;
	assign accept = s_tvalid && s_tready;
	assign record = accept && (s_tuser == skrgc_pkg::OP_RECORD);
	assign flush = accept && (s_tuser == skrgc_pkg::OP_FLUSH);
	assign grp = s_tdata[skrgc_pkg::KEY_FIELDS*skrgc_pkg::KEY_W +: skrgc_pkg::GROUP_W];

	// key compare lanes, merged by an or of their mismatch flags
	for (genvar k = 0; k < KEY_LANES; k++) begin : g_key
		skrgc_key_lane #(
			.LANE(k)
		) u_key (
			.clk(clk),
			.load(load_key),
			.key(s_tdata[k*skrgc_pkg::KEY_W +: skrgc_pkg::KEY_W]),
			.nk(nk),
			.prev(lane_prev[k]),
			.differs(lane_differs[k])
		);
		// words beyond the compared ones report as zero
		assign masked_key[k] = (skrgc_pkg::COV_W'(k) < nk) ? lane_prev[k] : '0;
	end

	assign differs = |lane_differs;

	// a new key or a flush ends the open stratum; a new key also starts the next one
	assign close = open_q && (flush || (record && differs));
	assign load_key = record && (!open_q || differs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			stratum_q <= '0;
		end else begin
			if (load_key) begin
				open_q <= 1'b1;
			end else if (close) begin
				open_q <= 1'b0;
			end
			if (close) begin
				stratum_q <= stratum_q + skrgc_pkg::NUM_W'(1);
			end
		end
	end

	// group count lanes: snapshot on close, then restart with the opening record
	assign cnt_ctl.record = record;
	assign cnt_ctl.close = close;
	assign cnt_ctl.grp = grp;
	assign cnt_ctl.ng = ng;

	for (genvar g = 0; g < GROUP_LANES; g++) begin : g_cnt
		skrgc_count_lane #(
			.LANE(g)
		) u_cnt (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(cnt_ctl),
			.snap(snap_counts[g])
		);
	end

	skrgc_emit #(
		.KEY_LANES(KEY_LANES),
		.GROUP_LANES(GROUP_LANES)
	) u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.start(close),
		.start_keys(masked_key),
		.start_num(stratum_q),
		.start_ng(ng),
		.counts(snap_counts),
		.busy(busy),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

endmodule

`default_nettype wire
